FILE: src/rcfp_pkg.sv
// Shared types and constants for the radio-receiver frame parser.
package rcfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned IndexW = 5;
  localparam int unsigned PosW   = 10;

  localparam logic [ByteW-1:0] START_BYTE    = 8'hA8;
  localparam logic [ByteW-1:0] STATUS_OK_MAX = 8'h01;
  localparam logic [WordW-1:0] CENTER_RESET  = 16'd12000;

  // Fixed byte positions inside a frame
  localparam logic [PosW-1:0] POS_STATUS = 10'd1;
  localparam logic [PosW-1:0] POS_COUNT  = 10'd2;
  localparam logic [PosW-1:0] POS_DATA0  = 10'd3;

  // One result beat
  typedef struct packed {
    logic                     chan_strobe;
    logic [IndexW-1:0]        chan_index;
    logic signed [WordW-1:0]  chan_value;
    logic                     frame_end;
    logic                     link_valid;
    logic                     failsafe_flag;
    logic                     in_frame;
  } rcfp_result_t;

endpackage

FILE: src/rcfp_byte_if.sv
// Byte channel: valid/ready handshake carrying one received serial byte.
interface rcfp_byte_if;
  logic                       valid;
  logic                       ready;
  logic [rcfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: src/rcfp_chan_if.sv
// Result channel: valid/ready handshake carrying decoded channel and link flags.
interface rcfp_chan_if;
  logic                               valid;
  logic                               ready;
  logic                               chan_strobe;
  logic [rcfp_pkg::IndexW-1:0]        chan_index;
  logic signed [rcfp_pkg::WordW-1:0]  chan_value;
  logic                               frame_end;
  logic                               link_valid;
  logic                               failsafe_flag;
  logic                               in_frame;

  modport source (output valid, output chan_strobe, output chan_index, output chan_value,
                  output frame_end, output link_valid, output failsafe_flag,
                  output in_frame, input ready);
  modport sink   (input valid, input chan_strobe, input chan_index, input chan_value,
                  input frame_end, input link_valid, input failsafe_flag,
                  input in_frame, output ready);
endinterface

FILE: src/rcfp_parser.sv
// Frame parser state and single-byte decode step.
module rcfp_parser #(
  parameter int unsigned MaxChannels = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        beat_i,
  input  logic [rcfp_pkg::ByteW-1:0]  rx_byte_i,
  input  logic [rcfp_pkg::WordW-1:0]  center_offset_i,
  output rcfp_pkg::rcfp_result_t      result_o
);
  import rcfp_pkg::*;

  localparam int unsigned ChW = PosW - 1;
  localparam logic [ChW-1:0] MaxCh = ChW'(MaxChannels);

  logic              frame_open_q, frame_open_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [ByteW-1:0]  count_q, count_d;
  logic [ByteW-1:0]  hold_q, hold_d;
  logic              failsafe_q, failsafe_d;
  logic              valid_q, valid_d;

  logic              open_now;
  logic [PosW-1:0]   pos;
  logic [PosW-1:0]   data_end;
  logic [ChW-1:0]    ch;
  logic [WordW-1:0]  word;

  assign open_now = frame_open_q || (rx_byte_i == START_BYTE);
  assign pos      = frame_open_q ? pos_q : '0;
  assign data_end = {1'b0, count_q, 1'b0} + POS_DATA0;
  assign ch       = pos[PosW-1:1] - ChW'(2);
  assign word     = {hold_q, rx_byte_i};

  // Decode one byte against the current frame position
  always_comb begin
    frame_open_d = frame_open_q;
    pos_d        = pos_q;
    count_d      = count_q;
    hold_d       = hold_q;
    failsafe_d   = failsafe_q;
    valid_d      = valid_q;
    result_o     = '0;

    if (open_now) begin
      frame_open_d = 1'b1;
      priority if (pos == POS_STATUS) begin
        if (rx_byte_i > STATUS_OK_MAX) begin
          failsafe_d = 1'b1;
          valid_d    = 1'b0;
        end else begin
          failsafe_d = 1'b0;
        end
      end else if (pos == POS_COUNT) begin
        count_d = rx_byte_i;
      end else if (pos > POS_COUNT && pos < data_end) begin
        if (pos[0]) begin
          hold_d = rx_byte_i;
        end else if (ch < MaxCh) begin
          result_o.chan_strobe = 1'b1;
          result_o.chan_index  = ch[IndexW-1:0];
          result_o.chan_value  = word - center_offset_i;
        end
      end else if (pos == data_end + PosW'(1)) begin
        frame_open_d = 1'b0;
        if (!failsafe_q) valid_d = 1'b1;
        result_o.frame_end = 1'b1;
      end
      pos_d = pos + PosW'(1);
    end

    result_o.link_valid    = valid_d;
    result_o.failsafe_flag = failsafe_d;
    result_o.in_frame      = frame_open_d;
  end

  // State update on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      pos_q        <= '0;
      count_q      <= '0;
      hold_q       <= '0;
      failsafe_q   <= 1'b0;
      valid_q      <= 1'b0;
    end else if (beat_i) begin
      frame_open_q <= frame_open_d;
      pos_q        <= pos_d;
      count_q      <= count_d;
      hold_q       <= hold_d;
      failsafe_q   <= failsafe_d;
      valid_q      <= valid_d;
    end
  end

endmodule

FILE: src/rc_receiver_frame_parser_top.sv
// Top level of the radio-receiver serial frame parser.
//
//   port      dir  beat contents
//   byte_i    in   rx_byte (one received serial byte)
//   result_o  out  chan_strobe, chan_index, chan_value, frame_end,
//                  link_valid, failsafe_flag, in_frame
//   cfg_*     in   center_offset write (no handshake)
//
// One byte per cycle unless a result stalls; each byte yields exactly one result beat, valid the cycle after.
// The result register sits between the sides: a new byte is taken while the
// previous result is taken in the same cycle, or when the register is empty.
// A stalled result holds the parser; reset clears frame state and flags,
// and sets center_offset to 12000.
module rc_receiver_frame_parser_top #(
  parameter int unsigned MAX_CHANNELS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rcfp_byte_if.sink                   byte_i,
  rcfp_chan_if.source                 result_o,
  input  logic                        cfg_we_i,
  input  logic [rcfp_pkg::WordW-1:0]  cfg_data_i
);
  import rcfp_pkg::*;

  logic [WordW-1:0] center_q;
  logic             beat;
  logic             out_valid_q;
  rcfp_result_t     res_d, res_q;

  assign byte_i.ready = !out_valid_q || result_o.ready;
  assign beat         = byte_i.valid && byte_i.ready;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CENTER_RESET;
    end else if (cfg_we_i) begin
      center_q <= cfg_data_i;
    end
  end

  rcfp_parser #(
    .MaxChannels (MAX_CHANNELS)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .beat_i          (beat),
    .rx_byte_i       (byte_i.rx_byte),
    .center_offset_i (center_q),
    .result_o        (res_d)
  );

  // Result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (beat) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (beat) res_q <= res_d;
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.chan_strobe   = res_q.chan_strobe;
  assign result_o.chan_index    = res_q.chan_index;
  assign result_o.chan_value    = res_q.chan_value;
  assign result_o.frame_end     = res_q.frame_end;
  assign result_o.link_valid    = res_q.link_valid;
  assign result_o.failsafe_flag = res_q.failsafe_flag;
  assign result_o.in_frame      = res_q.in_frame;

`ifndef SYNTHESIS
  // A byte cannot both complete a channel and close the frame
  a_strobe_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.chan_strobe && res_q.frame_end))
    else $error("channel strobe and frame end in one beat");

  // Link valid is never reported while failsafe is set
  a_valid_vs_failsafe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.link_valid && res_q.failsafe_flag))
    else $error("link valid with failsafe set");

  // Channel data only inside an open frame, frame end leaves it closed
  a_frame_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((!res_q.chan_strobe || res_q.in_frame)
                     && (!res_q.frame_end || !res_q.in_frame)))
    else $error("frame flag inconsistent with strobe or frame end");

  // Stalled result is not overwritten
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |=> (out_valid_q && $stable(res_q)))
    else $error("result changed while stalled");
`endif

endmodule

FILE: tb/rc_receiver_frame_parser_top_tb.sv
// Self-checking testbench for the radio-receiver frame parser: scripted and random frames.
module rc_receiver_frame_parser_top_tb;
  import rcfp_pkg::*;

  localparam int unsigned CHAN_LIMIT     = 32;
  localparam int unsigned PHASE_BYTES    = 305;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned SCRIPT_LEN     = 23;

  // One scripted byte; the result is typed in only where it is obvious
  typedef struct packed {
    logic [ByteW-1:0]  rx;
    logic              typed;
    logic              strobe;
    logic [IndexW-1:0] idx;
    logic [WordW-1:0]  val;
    logic              fend;
    logic              lv;
    logic              fs;
    logic              inf;
  } script_row_t;

  // Reset offset is 12000 (0x2EE0) throughout the script
  localparam script_row_t FRAME_SCRIPT [SCRIPT_LEN] = '{
    // idle line noise, ignored
    '{8'h00, 1'b1, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b1, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    // good frame, two channels, start byte reused as checksum high
    '{8'hA8, 1'b1, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1},
    '{8'h00, 1'b1, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1},
    '{8'h02, 1'b1, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1},
    '{8'h2E, 1'b1, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1},
    '{8'hE0, 1'b1, 1'b1, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1},
    '{8'hFF, 1'b0, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hA8, 1'b0, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b1, 1'b0, 5'd0, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0},
    // failsafe frame with no channels
    '{8'hA8, 1'b1, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b1},
    '{8'hFF, 1'b1, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b1},
    '{8'h00, 1'b0, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h12, 1'b0, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h34, 1'b1, 1'b0, 5'd0, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0},
    // status at the OK boundary clears failsafe, one channel
    '{8'hA8, 1'b0, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b1, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1},
    '{8'h01, 1'b0, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'h55, 1'b0, 1'b0, 5'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{8'hAA, 1'b1, 1'b0, 5'd0, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [WordW-1:0] cfg_data_i;

  rcfp_byte_if byte_bus ();
  rcfp_chan_if res_bus ();

  rc_receiver_frame_parser_top #(
    .MAX_CHANNELS(CHAN_LIMIT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_bus),
    .result_o   (res_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser mirror state
  logic              model_open;
  logic [PosW-1:0]   model_pos;
  logic [ByteW-1:0]  model_count;
  logic [ByteW-1:0]  model_high;
  logic              model_fs;
  logic              model_lv;
  logic [WordW-1:0]  model_offset;

  rcfp_result_t predicted_beats [$];

  int unsigned bytes_sent;
  int unsigned framed_bytes;
  int unsigned beats_checked;
  int unsigned words_strobed;
  int unsigned words_dropped;
  int unsigned frames_closed;
  int unsigned offsets_loaded;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  bit          sender_burst;
  bit          recv_burst;

  // Advance the mirror by one byte and return the beat it should produce
  function automatic rcfp_result_t parse_rx_byte(input logic [ByteW-1:0] b);
    rcfp_result_t    r;
    logic [PosW-1:0] data_end;
    logic [PosW-1:0] chan;
    r = '0;
    if (!model_open && b == START_BYTE) begin
      model_open = 1'b1;
      model_pos  = '0;
    end
    if (model_open) begin
      data_end = {1'b0, model_count, 1'b0} + POS_DATA0;
      chan     = (model_pos >> 1) - 10'd2;
      if (model_pos == POS_STATUS) begin
        if (b > STATUS_OK_MAX) begin
          model_fs = 1'b1;
          model_lv = 1'b0;
        end else begin
          model_fs = 1'b0;
        end
      end else if (model_pos == POS_COUNT) begin
        model_count = b;
      end else if (model_pos > POS_COUNT && model_pos < data_end) begin
        if (model_pos[0]) begin
          model_high = b;
        end else if (chan < CHAN_LIMIT) begin
          r.chan_strobe = 1'b1;
          r.chan_index  = chan[IndexW-1:0];
          r.chan_value  = {model_high, b} - model_offset;
          words_strobed++;
        end else begin
          words_dropped++;
        end
      end else if (model_pos == data_end + 10'd1) begin
        model_open = 1'b0;
        if (!model_fs) model_lv = 1'b1;
        r.frame_end = 1'b1;
        frames_closed++;
      end
      model_pos = model_pos + 10'd1;
    end
    r.link_valid    = model_lv;
    r.failsafe_flag = model_fs;
    r.in_frame      = model_open;
    return r;
  endfunction

  // Present one byte after a random gap; log its expected beat on acceptance
  task automatic send_byte(input logic [ByteW-1:0] b, input logic typed,
                           input rcfp_result_t want);
    int unsigned  gap;
    rcfp_result_t guess;
    gap = sender_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      byte_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_bus.valid   <= 1'b1;
    byte_bus.rx_byte <= b;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
    guess = parse_rx_byte(b);
    predicted_beats.push_back(typed ? want : guess);
    bytes_sent++;
    if (guess.in_frame || guess.frame_end) framed_bytes++;
  endtask

  // Drain, then write the centre offset while the parser is idle
  task automatic load_offset(input logic [WordW-1:0] v);
    byte_bus.valid <= 1'b0;
    while (predicted_beats.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    model_offset = v;
    offsets_loaded++;
  endtask

  // Mostly well-formed frames with random content; some cut short
  task automatic send_random_frame();
    int unsigned      n;
    int unsigned      pick;
    int unsigned      cut;
    int unsigned      k;
    logic [ByteW-1:0] status;
    logic [ByteW-1:0] b;
    logic [WordW-1:0] word;
    pick = $urandom_range(0, 99);
    if (pick < 75) n = $urandom_range(0, 8);
    else if (pick < 97) n = $urandom_range(9, 40);
    else n = $urandom_range(200, 255);
    pick = $urandom_range(0, 9);
    if (pick < 4) status = 8'h00;
    else if (pick < 6) status = STATUS_OK_MAX;
    else if (pick < 7) status = STATUS_OK_MAX + 8'd1;
    else status = ByteW'($urandom_range(0, 255));
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2 * n + 4) : 2 * n + 5;
    sender_burst = ($urandom_range(0, 3) == 0);
    word = '0;
    for (k = 0; k < cut; k++) begin
      if (k == 0) begin
        b = START_BYTE;
      end else if (k == 1) begin
        b = status;
      end else if (k == 2) begin
        b = n[ByteW-1:0];
      end else if (k < 2 * n + 3) begin
        if (((k - 3) % 2) == 0) begin
          pick = $urandom_range(0, 7);
          if (pick == 0) word = 16'h0000;
          else if (pick == 1) word = 16'hFFFF;
          else if (pick == 2) word = model_offset;
          else word = WordW'($urandom_range(0, 65535));
          b = word[WordW-1:ByteW];
        end else begin
          b = word[ByteW-1:0];
        end
      end else begin
        b = ByteW'($urandom_range(0, 255));
      end
      send_byte(b, 1'b0, '0);
    end
  endtask

  // Main sequence
  initial begin
    logic [WordW-1:0] offset_plan [6];
    script_row_t      row;
    rcfp_result_t     want;
    int unsigned      phase_start;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_data_i       = '0;
    byte_bus.valid   = 1'b0;
    byte_bus.rx_byte = '0;
    model_open       = 1'b0;
    model_pos        = '0;
    model_count      = '0;
    model_high       = '0;
    model_fs         = 1'b0;
    model_lv         = 1'b0;
    model_offset     = CENTER_RESET;
    sender_burst     = 1'b0;
    offset_plan = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000, CENTER_RESET};
    offset_plan[3] = WordW'($urandom_range(0, 65535));
    offset_plan[4] = WordW'($urandom_range(0, 65535));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Scripted frames at the reset offset
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      row  = FRAME_SCRIPT[i];
      want = {row.strobe, row.idx, row.val, row.fend, row.lv, row.fs, row.inf};
      send_byte(row.rx, row.typed, want);
    end

    // Random traffic under each offset setting
    foreach (offset_plan[p]) begin
      load_offset(offset_plan[p]);
      phase_start = framed_bytes;
      while (framed_bytes - phase_start < PHASE_BYTES) begin
        send_random_frame();
        repeat ($urandom_range(0, 2)) send_byte(ByteW'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    byte_bus.valid <= 1'b0;
    while (predicted_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("Sent %0d bytes (%0d within frames) across %0d offset settings; %0d beats checked.",
             bytes_sent, framed_bytes, offsets_loaded + 1, beats_checked);
    $display("Frames closed: %0d, channel words strobed: %0d, dropped past limit: %0d.",
             frames_closed, words_strobed, words_dropped);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result sink with random back-pressure
  initial begin
    rcfp_result_t got;
    rcfp_result_t want;
    int unsigned  stall;
    res_bus.ready = 1'b0;
    recv_burst    = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_bus.valid) @(posedge clk_i);
      got.chan_strobe   = res_bus.chan_strobe;
      got.chan_index    = res_bus.chan_index;
      got.chan_value    = res_bus.chan_value;
      got.frame_end     = res_bus.frame_end;
      got.link_valid    = res_bus.link_valid;
      got.failsafe_flag = res_bus.failsafe_flag;
      got.in_frame      = res_bus.in_frame;
      if (predicted_beats.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected beat: strobe=%0b idx=%0d val=%0d fend=%0b lv=%0b fs=%0b inf=%0b",
                   got.chan_strobe, got.chan_index, got.chan_value, got.frame_end,
                   got.link_valid, got.failsafe_flag, got.in_frame);
      end else begin
        want = predicted_beats.pop_front();
        if (got.chan_strobe !== want.chan_strobe || got.chan_index !== want.chan_index ||
            got.chan_value !== want.chan_value || got.frame_end !== want.frame_end ||
            got.link_valid !== want.link_valid || got.failsafe_flag !== want.failsafe_flag ||
            got.in_frame !== want.in_frame) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("beat %0d mismatch", beats_checked);
            $display("  exp strobe=%0b idx=%0d val=%0d fend=%0b lv=%0b fs=%0b inf=%0b",
                     want.chan_strobe, want.chan_index, want.chan_value, want.frame_end,
                     want.link_valid, want.failsafe_flag, want.in_frame);
            $display("  got strobe=%0b idx=%0d val=%0d fend=%0b lv=%0b fs=%0b inf=%0b",
                     got.chan_strobe, got.chan_index, got.chan_value, got.frame_end,
                     got.link_valid, got.failsafe_flag, got.in_frame);
          end
        end
      end
      beats_checked++;
    end
  end

  // Watchdog: counts cycles in which no beat moves on either side
  always @(posedge clk_i) begin
    if ((byte_bus.valid && byte_bus.ready) || (res_bus.valid && res_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

FILE: sim.f
src/rcfp_pkg.sv
src/rcfp_byte_if.sv
src/rcfp_chan_if.sv
src/rcfp_parser.sv
src/rc_receiver_frame_parser_top.sv
tb/rc_receiver_frame_parser_top_tb.sv
